### rtl/core/assert_macros.svh
// Assertion helpers; clk and rst are the sampling clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons holds in the same cycle as ante
`define QTE_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// cons holds in the cycle after ante
`define QTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/qte_pkg.sv
package qte_pkg;

  localparam int XY_W   = 40;  // CORDIC x/y width
  localparam int Z_W    = 34;  // Q30 radian accumulator
  localparam int S_W    = 32;  // clamped asin argument
  localparam int PROD_W = 34;  // Q30 product after floor shift
  localparam int ROOT_W = 31;  // sqrt result bits
  localparam int REM_W  = 62;  // sqrt remainder width
  localparam int TABLE_LEN = 24;

  localparam int PITCH_W = 15;
  localparam int ROLL_W  = 16;
  localparam int YAW_W   = 16;
  localparam int PITCH_LIM_DEG = 90;
  localparam int TURN_LIM_DEG  = 180;

  localparam int DEG_SCALE = 573;  // 57.3 * 10

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  z_t;
  typedef logic signed [S_W-1:0]  s_t;

  localparam xy_t ONE_XY   = 40'sd1073741824;
  localparam z_t  HALF_PI  = 34'sd1686629713;
  localparam logic signed [63:0] SQ_BASE = 64'sd1152921504606846976; // 2^60
  localparam logic [ROOT_W-1:0]  ROOT_MAX = 31'd1073741824;

  localparam z_t ATAN_TAB [TABLE_LEN] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  typedef struct packed {
    xy_t ry;
    xy_t rx;
    xy_t yy;
    xy_t yx;
  } ryv_t;

endpackage

### rtl/core/qte_cordic.sv
module qte_cordic #(
  parameter int STEPS = 16,
  parameter int FRAC  = 7,
  parameter int LIMIT = 180,
  parameter int OUT_W = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  qte_pkg::xy_t         x_in,
  input  qte_pkg::xy_t         y_in,
  output logic [OUT_W-1:0]     angle
);

  localparam int N     = (STEPS < qte_pkg::TABLE_LEN) ? STEPS : qte_pkg::TABLE_LEN;
  localparam int MAG_W = qte_pkg::Z_W - 1;
  localparam int P_W   = MAG_W + 10;
  localparam int SH_W  = P_W + FRAC + 1;
  localparam int Q_W   = SH_W - 30;
  localparam int M_W   = Q_W + 32;
  localparam int D_W   = M_W - 35;
  localparam logic [SH_W-1:0] HALF_DEN = SH_W'(5) << 30;
  localparam logic [31:0] RECIP = 32'hCCCCCCCD;   // q / 10 = (q * RECIP) >> 35
  localparam logic [31:0] LIM   = 32'(LIMIT) << FRAC;

  qte_pkg::xy_t xs [N+1];
  qte_pkg::xy_t ys [N+1];
  qte_pkg::z_t  zs [N+1];
  logic         zf [N+1];

  // quarter turn so x starts non-negative
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[qte_pkg::XY_W-1]) begin
        if (!y_in[qte_pkg::XY_W-1]) begin
          xs[0] <= y_in;
          ys[0] <= -x_in;
          zs[0] <= qte_pkg::HALF_PI;
        end else begin
          xs[0] <= -y_in;
          ys[0] <= x_in;
          zs[0] <= -qte_pkg::HALF_PI;
        end
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        zf[k+1] <= zf[k];
        if (!ys[k][qte_pkg::XY_W-1]) begin
          xs[k+1] <= xs[k] + (ys[k] >>> k);
          ys[k+1] <= ys[k] - (xs[k] >>> k);
          zs[k+1] <= zs[k] + qte_pkg::ATAN_TAB[k];
        end else begin
          xs[k+1] <= xs[k] - (ys[k] >>> k);
          ys[k+1] <= ys[k] + (xs[k] >>> k);
          zs[k+1] <= zs[k] - qte_pkg::ATAN_TAB[k];
        end
      end
    end
  end

  // radians to degrees, round half away from zero, clamp to +/-LIMIT
  qte_pkg::z_t      z_abs;
  logic [P_W-1:0]   prod_a;
  logic             neg_a;
  logic             neg_b;
  logic [SH_W-1:0]  sh_b;
  logic [Q_W-1:0]   q_b;
  logic [M_W-1:0]   prod_b;
  logic [D_W-1:0]   d_c;
  logic [31:0]      d_lim;
  logic [31:0]      d_sgn;

  assign z_abs = zs[N][qte_pkg::Z_W-1] ? -zs[N] : zs[N];
  assign sh_b  = {prod_a, {FRAC{1'b0}}} + HALF_DEN;
  assign q_b   = sh_b[SH_W-1:30];
  assign d_c   = prod_b[M_W-1:35];
  assign d_lim = (32'(d_c) > LIM) ? LIM : 32'(d_c);
  assign d_sgn = neg_b ? -d_lim : d_lim;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_a  <= zs[N][qte_pkg::Z_W-1] && !zf[N];
      prod_a <= zf[N] ? '0 : P_W'(z_abs[MAG_W-1:0]) * P_W'(qte_pkg::DEG_SCALE);
      neg_b  <= neg_a;
      prod_b <= M_W'(q_b) * M_W'(RECIP);
      angle  <= d_sgn[OUT_W-1:0];
    end
  end

endmodule

### rtl/core/quaternion_to_euler_angles_core.sv
// Quaternion (Q30 w,x,y,z) to ZYX Euler angles in degrees (x57.3 scale) with
// ANGLE_FRAC_BITS fraction bits. Fully pipelined: one word in per cycle while
// in_stall is low. The depth is set by the 31-stage square root feeding the pitch
// CORDIC, then the CORDIC_STEPS iteration stages (at most TABLE_LEN) and the
// degree scaling. Words with quat_valid low are taken and give no result. The
// whole pipe holds while out_stall is high and a result is waiting; in_stall
// follows it in that cycle.
`include "assert_macros.svh"

module quaternion_to_euler_angles_core #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          quat_w,
  input  logic signed [31:0]          quat_x,
  input  logic signed [31:0]          quat_y,
  input  logic signed [31:0]          quat_z,
  input  logic                        quat_valid,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [qte_pkg::PITCH_W-1:0] pitch_deg,
  output logic [qte_pkg::ROLL_W-1:0]  roll_deg,
  output logic [qte_pkg::YAW_W-1:0]   yaw_deg
);

  localparam int N = (CORDIC_STEPS < qte_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                        : qte_pkg::TABLE_LEN;
  localparam int SQ_DONE = 3 + qte_pkg::ROOT_W - 1;
  localparam int TOTAL   = SQ_DONE + 1 + 1 + N + 3;
  localparam int DLY     = qte_pkg::ROOT_W + 1;

  logic [TOTAL-1:0] vld;
  logic en;

  assign en        = !(vld[TOTAL-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], in_valid && quat_valid};
    end
  end

  // products, floor-shifted to Q30
  logic signed [63:0] m_wy, m_xz, m_yz, m_wx, m_xx, m_yy, m_xy, m_wz, m_ww, m_zz;
  logic signed [qte_pkg::PROD_W-1:0] p_wy, p_xz, p_yz, p_wx, p_xx, p_yy,
                                     p_xy, p_wz, p_ww, p_zz;

  assign m_wy = quat_w * quat_y;
  assign m_xz = quat_x * quat_z;
  assign m_yz = quat_y * quat_z;
  assign m_wx = quat_w * quat_x;
  assign m_xx = quat_x * quat_x;
  assign m_yy = quat_y * quat_y;
  assign m_xy = quat_x * quat_y;
  assign m_wz = quat_w * quat_z;
  assign m_ww = quat_w * quat_w;
  assign m_zz = quat_z * quat_z;

  always_ff @(posedge clk) begin
    if (en) begin
      p_wy <= m_wy[63:30];
      p_xz <= m_xz[63:30];
      p_yz <= m_yz[63:30];
      p_wx <= m_wx[63:30];
      p_xx <= m_xx[63:30];
      p_yy <= m_yy[63:30];
      p_xy <= m_xy[63:30];
      p_wz <= m_wz[63:30];
      p_ww <= m_ww[63:30];
      p_zz <= m_zz[63:30];
    end
  end

  // sums and asin argument clamp
  qte_pkg::xy_t s_raw;
  qte_pkg::xy_t s_clip;
  qte_pkg::s_t  s2;
  qte_pkg::ryv_t rd [DLY+1];

  assign s_raw  = (qte_pkg::xy_t'(p_wy) - qte_pkg::xy_t'(p_xz)) <<< 1;
  assign s_clip = (s_raw > qte_pkg::ONE_XY)  ? qte_pkg::ONE_XY :
                  (s_raw < -qte_pkg::ONE_XY) ? -qte_pkg::ONE_XY : s_raw;

  always_ff @(posedge clk) begin
    if (en) begin
      s2       <= s_clip[qte_pkg::S_W-1:0];
      rd[0].ry <= (qte_pkg::xy_t'(p_yz) + qte_pkg::xy_t'(p_wx)) <<< 1;
      rd[0].rx <= qte_pkg::ONE_XY -
                  ((qte_pkg::xy_t'(p_xx) + qte_pkg::xy_t'(p_yy)) <<< 1);
      rd[0].yy <= (qte_pkg::xy_t'(p_xy) + qte_pkg::xy_t'(p_wz)) <<< 1;
      rd[0].yx <= qte_pkg::xy_t'(p_ww) + qte_pkg::xy_t'(p_xx) -
                  qte_pkg::xy_t'(p_yy) - qte_pkg::xy_t'(p_zz);
    end
  end

  for (genvar j = 0; j < DLY; j++) begin : g_rdly
    always_ff @(posedge clk) begin
      if (en) begin
        rd[j+1] <= rd[j];
      end
    end
  end

  // 1 - s^2 for the cosine
  logic signed [63:0] ssq;
  logic [qte_pkg::REM_W-1:0] rem [qte_pkg::ROOT_W+1];
  logic [qte_pkg::ROOT_W-1:0] rt [1:qte_pkg::ROOT_W];
  qte_pkg::s_t sd [qte_pkg::ROOT_W+1];

  assign ssq = s2 * s2;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= qte_pkg::REM_W'(qte_pkg::SQ_BASE - ssq);
      sd[0]  <= s2;
    end
  end

  // square root, one result bit per stage, msb first
  for (genvar j = 0; j < qte_pkg::ROOT_W; j++) begin : g_sqrt
    localparam int B = qte_pkg::ROOT_W - 1 - j;
    logic [qte_pkg::ROOT_W-1:0] root_in;
    logic [qte_pkg::REM_W-1:0]  trial;
    if (j == 0) begin : g_first
      assign root_in = '0;
    end else begin : g_rest
      assign root_in = rt[j];
    end
    assign trial = (qte_pkg::REM_W'(root_in) << (B + 1)) +
                   (qte_pkg::REM_W'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        sd[j+1] <= sd[j];
        if (rem[j] >= trial) begin
          rem[j+1] <= rem[j] - trial;
          rt[j+1]  <= root_in | (qte_pkg::ROOT_W'(1) << B);
        end else begin
          rem[j+1] <= rem[j];
          rt[j+1]  <= root_in;
        end
      end
    end
  end

  qte_cordic #(
    .STEPS (CORDIC_STEPS),
    .FRAC  (ANGLE_FRAC_BITS),
    .LIMIT (qte_pkg::PITCH_LIM_DEG),
    .OUT_W (qte_pkg::PITCH_W)
  ) u_pitch (
    .clk   (clk),
    .en    (en),
    .x_in  (qte_pkg::xy_t'({1'b0, rt[qte_pkg::ROOT_W]})),
    .y_in  (qte_pkg::xy_t'(sd[qte_pkg::ROOT_W])),
    .angle (pitch_deg)
  );

  qte_cordic #(
    .STEPS (CORDIC_STEPS),
    .FRAC  (ANGLE_FRAC_BITS),
    .LIMIT (qte_pkg::TURN_LIM_DEG),
    .OUT_W (qte_pkg::ROLL_W)
  ) u_roll (
    .clk   (clk),
    .en    (en),
    .x_in  (rd[DLY].rx),
    .y_in  (rd[DLY].ry),
    .angle (roll_deg)
  );

  qte_cordic #(
    .STEPS (CORDIC_STEPS),
    .FRAC  (ANGLE_FRAC_BITS),
    .LIMIT (qte_pkg::TURN_LIM_DEG),
    .OUT_W (qte_pkg::YAW_W)
  ) u_yaw (
    .clk   (clk),
    .en    (en),
    .x_in  (rd[DLY].yx),
    .y_in  (rd[DLY].yy),
    .angle (yaw_deg)
  );

  `QTE_ASSERT_NEXT(a_enter, in_valid && !in_stall, vld[0] == $past(quat_valid))
  `QTE_ASSERT_IMPLY(a_clamp, vld[1], (s2 <= 32'sd1073741824) && (s2 >= -32'sd1073741824))
  `QTE_ASSERT_IMPLY(a_root, vld[SQ_DONE], rt[qte_pkg::ROOT_W] <= qte_pkg::ROOT_MAX)

endmodule

### dv/quaternion_to_euler_angles_core_tb.sv
`timescale 1ns / 1ps

module quaternion_to_euler_angles_core_tb;

  localparam int FRAC = 7;
  localparam int STEPS = 16;
  localparam int LATENCY = 38 + STEPS;
  localparam int WATCHDOG = 4000;
  localparam int N_RANDOM = 1950;
  localparam longint Q1 = 64'sd1073741824;

  typedef enum int {MODE_CLEAN, MODE_SRC_IDLE, MODE_SINK_STALL, MODE_BOTH} idle_mode_t;

  typedef struct {
    logic [qte_pkg::PITCH_W-1:0] pitch;
    logic [qte_pkg::ROLL_W-1:0]  roll;
    logic [qte_pkg::YAW_W-1:0]   yaw;
  } angles_t;

  typedef struct {
    logic signed [31:0] w, x, y, z;
    logic               vld;
    bit                 typed;   // expected angles given in the row
    angles_t            ang;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic quat_valid = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [qte_pkg::PITCH_W-1:0] pitch_deg;
  logic [qte_pkg::ROLL_W-1:0]  roll_deg;
  logic [qte_pkg::YAW_W-1:0]   yaw_deg;

  angles_t    angle_queue[$];
  int         errors = 0;
  int         words_in = 0, results_seen = 0;
  int         idle_cycles = 0;
  idle_mode_t mode = MODE_CLEAN;

  quaternion_to_euler_angles_core #(.ANGLE_FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .quat_valid(quat_valid), .out_valid(out_valid), .out_stall(out_stall),
    .pitch_deg(pitch_deg), .roll_deg(roll_deg), .yaw_deg(yaw_deg)
  );

  always #10 clk = ~clk;

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return floor_shr(a * b, 30);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = qte_pkg::HALF_PI;
      end else begin
        x = -y; y = t; z = -qte_pkg::HALF_PI;
      end
    end
    for (int i = 0; i < STEPS && i < qte_pkg::TABLE_LEN; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += qte_pkg::ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= qte_pkg::ATAN_TAB[i];
      end
    end
    return z;
  endfunction

  function automatic longint rad_to_deg(longint rad, longint lim_deg);
    longint unsigned mag, num, den;
    longint d, lim;
    mag = (rad < 0) ? longint'(-rad) : longint'(rad);
    num = (mag * qte_pkg::DEG_SCALE) << FRAC;
    den = 64'd10 << 30;
    d = longint'((num + den / 2) / den);
    lim = lim_deg <<< FRAC;
    if (rad < 0) d = -d;
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return d;
  endfunction

  function automatic angles_t euler_from_quat(longint w, longint x, longint y, longint z);
    angles_t a;
    longint s, c, ry, rx, yy, yx;
    s = 2 * (q30_mul(w, y) - q30_mul(x, z));
    if (s > Q1) s = Q1;
    if (s < -Q1) s = -Q1;
    c = int_sqrt(longint'(Q1 * Q1 - s * s));
    ry = 2 * (q30_mul(y, z) + q30_mul(w, x));
    rx = Q1 - 2 * (q30_mul(x, x) + q30_mul(y, y));
    yy = 2 * (q30_mul(x, y) + q30_mul(w, z));
    yx = q30_mul(w, w) + q30_mul(x, x) - q30_mul(y, y) - q30_mul(z, z);
    a.pitch = qte_pkg::PITCH_W'(rad_to_deg(vec_angle(s, c), qte_pkg::PITCH_LIM_DEG));
    a.roll  = qte_pkg::ROLL_W'(rad_to_deg(vec_angle(ry, rx), qte_pkg::TURN_LIM_DEG));
    a.yaw   = qte_pkg::YAW_W'(rad_to_deg(vec_angle(yy, yx), qte_pkg::TURN_LIM_DEG));
    return a;
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic int src_idle_pct();
    return (mode == MODE_SRC_IDLE) ? 54 : (mode == MODE_BOTH) ? 6 : 0;
  endfunction

  function automatic int sink_stall_pct();
    return (mode == MODE_SINK_STALL) ? 54 : (mode == MODE_BOTH) ? 6 : 0;
  endfunction

  // random Q30 component; mostly in range, sometimes full 32-bit noise
  function automatic logic signed [31:0] rand_part();
    case ($urandom_range(9, 0))
      0: return $urandom;
      1: return $urandom_range(3, 0) == 0 ? -32'sd1073741824 : 32'sd1073741824;
      2: return $signed($urandom_range(255, 0)) - 128;
      default: return $signed($urandom_range(32'h7FFF_FFFF, 0)) - 32'sd1073741824;
    endcase
  endfunction

  // unit quaternion built from two random unit pairs
  task automatic rand_unit(output logic signed [31:0] w, x, y, z);
    real a, b, c, r1, r2, n;
    a = $urandom / 4294967296.0;
    b = 6.2831853 * ($urandom / 4294967296.0);
    c = 6.2831853 * ($urandom / 4294967296.0);
    r1 = $sqrt(1.0 - a);
    r2 = $sqrt(a);
    n = 1073741823.0;
    w = $rtoi(n * r1 * $sin(b));
    x = $rtoi(n * r1 * $cos(b));
    y = $rtoi(n * r2 * $sin(c));
    z = $rtoi(n * r2 * $cos(c));
  endtask

  task automatic send_word(stim_row_t r);
    angles_t e;
    while (chance(src_idle_pct())) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    quat_w <= r.w; quat_x <= r.x; quat_y <= r.y; quat_z <= r.z;
    quat_valid <= r.vld;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_in++;
    if (r.vld) begin
      e = euler_from_quat(r.w, r.x, r.y, r.z);
      if (r.typed && (e.pitch != r.ang.pitch || e.roll != r.ang.roll || e.yaw != r.ang.yaw))
        $display("note: typed row %0d differs from predictor", words_in);
      angle_queue.push_back(r.typed ? r.ang : e);
    end
  endtask

  // sink stall and result check
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (angle_queue.size() == 0) begin
          $error("unexpected word: pitch %0h roll %0h yaw %0h", pitch_deg, roll_deg, yaw_deg);
          errors++;
        end else begin
          angles_t e;
          e = angle_queue.pop_front();
          if (pitch_deg !== e.pitch) begin
            $error("pitch_deg: expected %0h got %0h", e.pitch, pitch_deg); errors++;
          end
          if (roll_deg !== e.roll) begin
            $error("roll_deg: expected %0h got %0h", e.roll, roll_deg); errors++;
          end
          if (yaw_deg !== e.yaw) begin
            $error("yaw_deg: expected %0h got %0h", e.yaw, yaw_deg); errors++;
          end
        end
      end
      out_stall <= chance(sink_stall_pct());
    end
  end

  // watchdog on cycles without any accepted word or taken result
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout after %0d quiet cycles", WATCHDOG);
      $display("quaternion_to_euler_angles_core_tb: done, errors");
      $finish;
    end
  end

  // directed table; angles typed only where obvious (identity, zero vector, negated identity)
  localparam int N_DIR = 20;
  localparam logic signed [31:0] P1 = 32'sd1073741824;
  localparam logic signed [31:0] M1 = -32'sd1073741824;
  stim_row_t dir_tab [N_DIR];

  initial begin
    stim_row_t r;
    dir_tab[0]  = '{P1, 0, 0, 0, 1, 1, '{15'd0, 16'd0, 16'd0}};        // identity
    dir_tab[1]  = '{0, 0, 0, 0, 1, 1, '{15'd0, 16'd0, 16'd0}};         // zero vector
    dir_tab[2]  = '{M1, 0, 0, 0, 1, 1, '{15'd0, 16'd0, 16'd0}};
    dir_tab[3]  = '{P1, P1, P1, P1, 0, 0, '{0, 0, 0}};                  // no quaternion
    dir_tab[4]  = '{0, P1, 0, 0, 1, 0, '{0, 0, 0}};                     // roll half turn
    dir_tab[5]  = '{0, 0, P1, 0, 1, 0, '{0, 0, 0}};
    dir_tab[6]  = '{0, 0, 0, P1, 1, 0, '{0, 0, 0}};                     // yaw half turn
    dir_tab[7]  = '{P1, 0, P1, 0, 1, 0, '{0, 0, 0}};                    // asin saturates high
    dir_tab[8]  = '{P1, 0, M1, 0, 1, 0, '{0, 0, 0}};                    // asin saturates low
    dir_tab[9]  = '{P1, P1, P1, P1, 1, 0, '{0, 0, 0}};
    dir_tab[10] = '{M1, M1, M1, M1, 1, 0, '{0, 0, 0}};
    dir_tab[11] = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1, 0, '{0,0,0}};
    dir_tab[12] = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 0, '{0,0,0}};
    dir_tab[13] = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1, 0, '{0,0,0}};
    dir_tab[14] = '{759250125, 759250125, 0, 0, 1, 0, '{0, 0, 0}};      // roll 90
    dir_tab[15] = '{759250125, 0, 759250125, 0, 1, 0, '{0, 0, 0}};      // pitch at the +90 degree limit
    dir_tab[16] = '{759250125, 0, 0, -759250125, 1, 0, '{0, 0, 0}};     // yaw -90
    dir_tab[17] = '{-1, 0, 0, 1, 1, 0, '{0, 0, 0}};                     // yaw vector on the -y axis
    dir_tab[18] = '{0, 0, 0, -1, 1, 0, '{0, 0, 0}};
    dir_tab[19] = '{0, P1, 0, 1, 1, 0, '{0, 0, 0}};                     // roll near +180

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_word(dir_tab[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      // idling phases, with clean stretches in between
      if (n % 250 == 0) mode = idle_mode_t'((n / 250) % 4);
      r.typed = 0;
      r.ang = '{0, 0, 0};
      r.vld = !chance(8);
      if (chance(75)) begin
        rand_unit(r.w, r.x, r.y, r.z);
        if (chance(20)) begin
          r.w = -r.w;  // sign flips hit other quadrants
          r.x = chance(50) ? -r.x : r.x;
        end
      end else begin
        r.w = rand_part(); r.x = rand_part(); r.y = rand_part(); r.z = rand_part();
      end
      send_word(r);
    end
    in_valid <= 1'b0;
    mode = MODE_CLEAN;

    while (angle_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (angle_queue.size() != 0) begin
      $error("%0d expected words never arrived", angle_queue.size());
      errors++;
    end
    $display("covered %0d input words (%0d directed), %0d result words checked,",
             words_in, N_DIR, results_seen);
    $display("four idle/stall phases including random quaternions and saturating corners");
    if (errors == 0) begin
      $display("quaternion_to_euler_angles_core_tb: done, clean");
    end else begin
      $display("quaternion_to_euler_angles_core_tb: done, errors");
    end
    $finish;
  end

endmodule
